// File: design/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sha1md_pkg;

  localparam int unsigned CountW = 61;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0]        PAD_BYTE    = 8'h80;
  localparam logic [CountW-1:0] COUNT_MAX   = {CountW{1'b1}};
  localparam logic [5:0]        BLOCK_LAST  = 6'd63;
  localparam logic [5:0]        LEN_POS     = 6'd56;
  localparam logic [6:0]        ROUND_LAST  = 7'd79;
  localparam logic [6:0]        ROUND_P1    = 7'd20;
  localparam logic [6:0]        ROUND_P2    = 7'd40;
  localparam logic [6:0]        ROUND_P3    = 7'd60;
  localparam logic [4:0]        DIGEST_LAST = 5'd19;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_e;

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_XOR = 2'd1,
    PH_MAJ = 2'd2,
    PH_PAR = 2'd3
  } phase_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e byte_sel;
    logic      count_inc;
    logic      load_work;
    logic      do_round;
    phase_e    phase;
    logic      add_chain;
    logic      out_shift;
    logic      msg_done;
  } sha1md_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       count_sat;
  } sha1md_sts_t;

endpackage

// File: design/sha1md_ctrl.sv
// Sequencer for the SHA-1 core: byte intake, padding, rounds, digest output.
// Depends on sha1md_pkg; drives the datapath through sha1md_cmd_t.
`timescale 1ns / 1ps

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        digest_last_o,
  input  sha1md_sts_t sts_i,
  output sha1md_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [6:0] round_q, round_d;
  logic [4:0] cnt_q, cnt_d;
  logic       pad_first_q, pad_first_d;
  logic       len_blk_q, len_blk_d;
  logic       padding_q, padding_d;
  logic       eom_pend_q, eom_pend_d;

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    pad_first_d = pad_first_q;
    len_blk_d   = len_blk_q;
    padding_d   = padding_q;
    eom_pend_d  = eom_pend_q;
    cmd_o       = '0;
    cmd_o.byte_sel = SEL_DATA;

    priority if (round_q < ROUND_P1) begin
      cmd_o.phase = PH_CH;
    end else if (round_q < ROUND_P2) begin
      cmd_o.phase = PH_XOR;
    end else if (round_q < ROUND_P3) begin
      cmd_o.phase = PH_MAJ;
    end else begin
      cmd_o.phase = PH_PAR;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i && !sts_i.count_sat) begin
            cmd_o.shift_en  = 1'b1;
            cmd_o.count_inc = 1'b1;
            if (sts_i.pos == BLOCK_LAST) begin
              cmd_o.load_work = 1'b1;
              eom_pend_d      = end_of_message_i;
              round_d         = '0;
              state_d         = S_ROUND;
            end else if (end_of_message_i) begin
              pad_first_d = 1'b1;
              padding_d   = 1'b1;
              state_d     = S_PAD;
            end
          end else if (end_of_message_i) begin
            pad_first_d = 1'b1;
            padding_d   = 1'b1;
            state_d     = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (pad_first_q) begin
          cmd_o.byte_sel = SEL_PAD;
          pad_first_d    = 1'b0;
          len_blk_d      = (sts_i.pos < LEN_POS);
        end else if (len_blk_q && (sts_i.pos >= LEN_POS)) begin
          cmd_o.byte_sel = SEL_LEN;
        end else begin
          cmd_o.byte_sel = SEL_ZERO;
        end
        if (sts_i.pos == BLOCK_LAST) begin
          cmd_o.load_work = 1'b1;
          round_d         = '0;
          state_d         = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.do_round = 1'b1;
        round_d        = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_chain = 1'b1;
        if (padding_q) begin
          if (len_blk_q) begin
            padding_d = 1'b0;
            cnt_d     = '0;
            state_d   = S_OUT;
          end else begin
            len_blk_d = 1'b1;
            state_d   = S_PAD;
          end
        end else if (eom_pend_q) begin
          eom_pend_d  = 1'b0;
          pad_first_d = 1'b1;
          padding_d   = 1'b1;
          state_d     = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.out_shift = 1'b1;
          if (cnt_q == DIGEST_LAST) begin
            cmd_o.msg_done = 1'b1;
            cnt_d          = '0;
            state_d        = S_IDLE;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      cnt_q       <= '0;
      pad_first_q <= 1'b0;
      len_blk_q   <= 1'b0;
      padding_q   <= 1'b0;
      eom_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      cnt_q       <= cnt_d;
      pad_first_q <= pad_first_d;
      len_blk_q   <= len_blk_d;
      padding_q   <= padding_d;
      eom_pend_q  <= eom_pend_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_last_o = (state_q == S_OUT) && (cnt_q == DIGEST_LAST);

endmodule

// File: design/sha1md_dp.sv
// Datapath of the SHA-1 core: block shift register with schedule window,
// round registers, chaining state and message length. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_dp
  import sha1md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  sha1md_cmd_t cmd_i,
  output sha1md_sts_t sts_o,
  output logic [7:0]  digest_byte_o
);

  logic [31:0]       blk_q [16];
  logic [31:0]       chain_q [5];
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;
  logic [CountW-1:0] count_q;
  logic [5:0]        pos_q;

  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  in_byte;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  assign len_bits = {count_q, 3'b000};
  assign len_byte = len_bits[{~pos_q[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd_i.byte_sel)
      SEL_DATA: in_byte = data_byte_i;
      SEL_PAD:  in_byte = PAD_BYTE;
      SEL_ZERO: in_byte = 8'h00;
      SEL_LEN:  in_byte = len_byte;
      default:  in_byte = 8'h00;
    endcase
  end

  assign w_new = {blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0]} << 1
               | {31'd0, (blk_q[13][31] ^ blk_q[8][31] ^ blk_q[2][31] ^ blk_q[0][31])};

  always_comb begin
    unique case (cmd_i.phase)
      PH_CH: begin
        f_val = (b_q & c_q) | (~b_q & d_q);
        k_val = K0;
      end
      PH_XOR: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K1;
      end
      PH_MAJ: begin
        f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k_val = K2;
      end
      PH_PAR: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K3;
      end
      default: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K3;
      end
    endcase
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + blk_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
      end
      blk_q[15] <= {blk_q[15][23:0], in_byte};
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= blk_q[i+1];
      end
      blk_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.do_round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= H0;
      chain_q[1] <= H1;
      chain_q[2] <= H2;
      chain_q[3] <= H3;
      chain_q[4] <= H4;
    end else if (cmd_i.msg_done) begin
      chain_q[0] <= H0;
      chain_q[1] <= H1;
      chain_q[2] <= H2;
      chain_q[3] <= H3;
      chain_q[4] <= H4;
    end else if (cmd_i.add_chain) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
      chain_q[4] <= chain_q[4] + e_q;
    end else if (cmd_i.out_shift) begin
      for (int i = 0; i < 4; i++) begin
        chain_q[i] <= {chain_q[i][23:0], chain_q[i+1][31:24]};
      end
      chain_q[4] <= {chain_q[4][23:0], 8'h00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.msg_done) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.count_inc) begin
        count_q <= count_q + {{(CountW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.shift_en) begin
        pos_q <= pos_q + 6'd1;
      end
    end
  end

  assign sts_o.pos       = pos_q;
  assign sts_o.count_sat = (count_q == COUNT_MAX);
  assign digest_byte_o   = chain_q[0][31:24];

endmodule

// File: design/sha1_message_digest_core.sv
// Top level of the SHA-1 message digest core.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_dp.
`timescale 1ns / 1ps

// SHA-1 over a byte stream. Each input transaction carries an optional
// message byte (has_byte_i) and an end mark; at the end mark the core pads
// the message and returns the 20 digest bytes, most significant first, with
// digest_last_o on the final one, then restarts from the initial chain.
// A byte that does not complete a 64-byte block is just shifted in; one that
// completes it starts the 80 rounds, one per cycle in a single round unit
// with input stalled, then a fold into the chain. At the end mark, padding
// shifts one byte per cycle into the block (plus a block if the length does
// not fit), each padded block runs rounds and fold, and the digest leaves at
// one byte per cycle while out_stall_i is low. Input stalls from the end mark
// until the last digest byte is taken. Messages over 2^61-1 bytes saturate.
module sha1_message_digest_core
  import sha1md_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] digest_byte_o,
  output logic       digest_last_o
);

  sha1md_cmd_t cmd;
  sha1md_sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_last_o    (digest_last_o),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  sha1md_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_byte_o (digest_byte_o)
  );

endmodule

// File: design/sha1md_chk.sv
// Port-level checker for the SHA-1 message digest core, bound to the top.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module sha1md_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] digest_byte_o,
  input logic       digest_last_o
);

  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while digest is being delivered");

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_last_o |-> out_valid_o)
    else $error("digest_last without a valid output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(digest_byte_o) && $stable(digest_last_o)))
    else $error("stalled output changed");

  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && digest_last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("core did not return to idle after the last digest byte");

endmodule

bind sha1_message_digest_core sha1md_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_byte_o (digest_byte_o),
  .digest_last_o (digest_last_o)
);
